@@ design/tpos_pkg.sv @@
// ----------------------------------------------------------------------------
// tpos_pkg
// Shared types and constants of the two pulse / one sawtooth sound generator.
// ----------------------------------------------------------------------------
package tpos_pkg;

    // step registers and configuration port
    localparam int CFG_W     = 30;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAW_STEP    = 1'b1;
    localparam logic [CFG_W-1:0] SQUARE_STEP_RST = 30'd886582;
    localparam logic [CFG_W-1:0] SAW_STEP_RST    = 30'd443291;

    localparam int FRACTION_BITS_DEF = 18;

    // input item
    localparam int ADDR_W  = 16;
    localparam int VALUE_W = 8;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // channel select in address bits 15:12
    localparam logic [3:0] SEL_PULSE_A = 4'h9;
    localparam logic [3:0] SEL_PULSE_B = 4'hA;
    localparam logic [3:0] SEL_SAW     = 4'hB;

    // register select in address bits 1:0
    localparam logic [1:0] REG_VOL    = 2'd0;
    localparam logic [1:0] REG_PER_LO = 2'd1;
    localparam logic [1:0] REG_PER_HI = 2'd2;
    localparam logic [1:0] REG_SPARE  = 2'd3;

    // channels
    localparam int NUM_CH    = 3;
    localparam int NUM_PULSE = 2;
    localparam int CH_W      = 2;
    localparam logic [CH_W-1:0] CH_PULSE_A = 2'd0;
    localparam logic [CH_W-1:0] CH_PULSE_B = 2'd1;
    localparam logic [CH_W-1:0] CH_SAW     = 2'd2;

    // period is 12 bits plus one
    localparam int PER_W = 13;

    // sawtooth
    localparam int SAW_STEPS  = 7;
    localparam int SAW_POS_W  = 3;
    localparam int SAW_ACC_W  = 9;
    localparam int PULSE_POS_W = 4;

    // result item
    localparam int PULSE_LVL_W = 4;
    localparam int SAW_LVL_W   = 5;
    localparam int MIX_LVL_W   = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CMP,
        S_DEF,
        S_DIV,
        S_FIX,
        S_APPLY,
        S_DONE
    } state_t;

endpackage

@@ design/tpos_if.sv @@
// ----------------------------------------------------------------------------
// tpos_cmd_if / tpos_sample_if
// Valid/ready channels for command items and sample results.
// ----------------------------------------------------------------------------
interface tpos_cmd_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [tpos_pkg::ADDR_W-1:0]  address;
    logic [tpos_pkg::VALUE_W-1:0] value;

    modport source (output valid, output opcode, output address, output value,
                    input ready);
    modport sink   (input valid, input opcode, input address, input value,
                    output ready);
endinterface

interface tpos_sample_if;
    logic                             valid;
    logic                             ready;
    logic [tpos_pkg::PULSE_LVL_W-1:0] pulse_a_level;
    logic [tpos_pkg::PULSE_LVL_W-1:0] pulse_b_level;
    logic [tpos_pkg::SAW_LVL_W-1:0]   saw_level;
    logic [tpos_pkg::MIX_LVL_W-1:0]   mixed_level;

    modport source (output valid, output pulse_a_level, output pulse_b_level,
                    output saw_level, output mixed_level, input ready);
    modport sink   (input valid, input pulse_a_level, input pulse_b_level,
                    input saw_level, input mixed_level, output ready);
endinterface

@@ design/two_pulse_one_saw_sound_generator_unit.sv @@
// ----------------------------------------------------------------------------
// two_pulse_one_saw_sound_generator_unit
// Two pulse channels and one sawtooth channel; one level set per sample tick.
// ----------------------------------------------------------------------------
//  port      dir   handshake      carries
//  cfg_*     in    cfg_we only    step register writes
//  cmd       in    valid/ready    opcode, address, value
//  sample    out   valid/ready    three channel levels and their mix
//
//  A register write is taken in the idle state. A sample tick compares
//  each channel's phase with its step; one whose phase underflows also takes
//  QW = 30 - FRACTION_BITS restoring division steps in the shared subtractor.
//  cmd is held off while a tick is in progress; writes pass while a result
//  waits in the output register, the next tick stalls only at its end.
//  Reset is asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module two_pulse_one_saw_sound_generator_unit #(
    parameter int FRACTION_BITS = tpos_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpos_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpos_pkg::CFG_W-1:0]     cfg_data,
    tpos_cmd_if.sink                       cmd,
    tpos_sample_if.source                  sample
);
    import tpos_pkg::*;

    localparam int QW      = CFG_W - FRACTION_BITS;
    localparam int PHASE_W = PER_W - 1 + FRACTION_BITS;
    localparam int SP_W    = PER_W + FRACTION_BITS;
    localparam int SUB_W   = (SP_W > CFG_W) ? SP_W : CFG_W;
    localparam int CNT_W   = $clog2(QW);

    // architectural state
    logic [CFG_W-1:0]       square_step_reg;
    logic [CFG_W-1:0]       saw_step_reg;
    logic [7:0]             vol_reg    [NUM_CH];
    logic [7:0]             per_lo_reg [NUM_CH];
    logic [7:0]             per_hi_reg [NUM_CH];
    logic [NUM_CH-1:0]      pend_reg;
    logic [PER_W-1:0]       per_reg    [NUM_CH];
    logic [PHASE_W-1:0]     phase_reg  [NUM_CH];
    logic [PULSE_POS_W-1:0] pos_reg    [NUM_PULSE];
    logic [SAW_POS_W-1:0]   saw_pos_reg;
    logic [SAW_ACC_W-1:0]   acc_reg;

    // sequencer
    state_t           state_reg, state_next;
    logic [CH_W-1:0]  ch_reg;
    logic             out_valid_reg;
    logic             out_load;
    logic             tick_accept;
    logic             wr_accept;

    // division / underflow count
    logic [PER_W-1:0]         rem_reg;
    logic [QW-1:0]            dq_reg;
    logic [FRACTION_BITS-1:0] dl_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [2:0]               qm7_reg;
    logic                     qbig_reg;
    logic [PULSE_POS_W-1:0]   n4_reg;
    logic [2:0]               nm7_reg;
    logic                     nbig_reg;

    // levels
    logic [PULSE_LVL_W-1:0] lvl_a_reg, lvl_b_reg;
    logic [SAW_LVL_W-1:0]   lvl_s_reg;
    logic [PULSE_LVL_W-1:0] out_a_reg, out_b_reg;
    logic [SAW_LVL_W-1:0]   out_s_reg;
    logic [MIX_LVL_W-1:0]   out_mix_reg;

    // shared subtractor
    logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
    logic             sub_borrow;

    tpos_sub #(.W(SUB_W)) u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // ------------------------------------------------------------------
    // channel operands
    logic [CFG_W-1:0]       cur_step;
    logic [PER_W-1:0]       cur_per;
    logic [PHASE_W-1:0]     cur_phase;
    logic [7:0]             cur_vol;
    logic                   cur_en;
    logic                   cur_live;
    logic                   r_zero;
    logic                   q_bit;
    logic [3:0]             qm7_t;
    logic                   qm7_ge7;
    logic [2:0]             qm7_next;
    logic [PULSE_POS_W-1:0] pos_next;
    logic [PULSE_LVL_W-1:0] pulse_lvl;
    logic [3:0]             saw_sum;
    logic                   saw_wrap;
    logic [SAW_POS_W-1:0]   saw_pos_next;
    logic [SAW_ACC_W-1:0]   acc_next;
    logic [SAW_LVL_W-1:0]   saw_lvl;
    logic [5:0]             saw_rate;

    assign cur_step  = (ch_reg == CH_SAW) ? saw_step_reg : square_step_reg;
    assign cur_per   = per_reg[ch_reg];
    assign cur_phase = phase_reg[ch_reg];
    assign cur_vol   = vol_reg[ch_reg];
    assign cur_en    = per_hi_reg[ch_reg][7];
    assign cur_live  = (cur_per != '0);
    assign r_zero    = (rem_reg == '0) && (dl_reg == '0);

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            S_CMP:
            begin
                sub_a = SUB_W'(cur_phase);
                sub_b = SUB_W'(cur_step);
            end
            S_DEF:
            begin
                sub_a = SUB_W'(cur_step);
                sub_b = SUB_W'(cur_phase);
            end
            S_DIV:
            begin
                sub_a = SUB_W'({rem_reg, dq_reg[QW-1]});
                sub_b = SUB_W'(cur_per);
            end
            S_FIX:
            begin
                sub_a = SUB_W'({cur_per, {FRACTION_BITS{1'b0}}});
                sub_b = SUB_W'({rem_reg, dl_reg});
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    // quotient mod 7 and "quotient >= 7", built up one bit per step
    assign q_bit    = !sub_borrow;
    assign qm7_t    = {qm7_reg, q_bit};
    assign qm7_ge7  = (qm7_t >= 4'd7);
    assign qm7_next = qm7_ge7 ? 3'(qm7_t - 4'd7) : qm7_t[2:0];

    // pulse channel
    assign pos_next  = pos_reg[ch_reg[0]] + n4_reg;
    assign pulse_lvl = (!cur_live || !cur_en ||
                        (!cur_vol[7] && (pos_next <= PULSE_POS_W'(cur_vol[6:4]))))
                       ? '0 : cur_vol[3:0];

    // sawtooth channel
    assign saw_rate     = vol_reg[CH_SAW][5:0];
    assign saw_sum      = {1'b0, saw_pos_reg} + {1'b0, nm7_reg};
    assign saw_wrap     = nbig_reg || (saw_sum >= 4'(SAW_STEPS));
    assign saw_pos_next = (saw_sum >= 4'(SAW_STEPS)) ? 3'(saw_sum - 4'(SAW_STEPS))
                                                     : saw_sum[2:0];
    assign acc_next     = saw_wrap
                          ? SAW_ACC_W'(saw_pos_next) * SAW_ACC_W'(saw_rate)
                          : acc_reg + SAW_ACC_W'(nm7_reg) * SAW_ACC_W'(saw_rate);
    assign saw_lvl      = (!cur_live || !cur_en) ? '0 : acc_next[7:3];

    // ------------------------------------------------------------------
    // write decode
    logic [CH_W-1:0] wr_ch;
    logic            wr_hit;
    logic [1:0]      wr_reg;

    assign wr_reg = cmd.address[1:0];

    always_comb
    begin
        wr_ch  = CH_PULSE_A;
        wr_hit = 1'b1;
        case (cmd.address[15:12])
            SEL_PULSE_A: wr_ch = CH_PULSE_A;
            SEL_PULSE_B: wr_ch = CH_PULSE_B;
            SEL_SAW:     wr_ch = CH_SAW;
            default:     wr_hit = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.ready   = 1'b0;
        out_load    = 1'b0;
        tick_accept = 1'b0;
        wr_accept   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    if (cmd.opcode == OP_TICK)
                    begin
                        tick_accept = 1'b1;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        wr_accept = 1'b1;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cur_live && sub_borrow)
                    state_next = S_DEF;
                else
                    state_next = S_APPLY;
            end
            S_DEF:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (ch_reg == CH_SAW)
                    state_next = S_DONE;
                else
                    state_next = S_LOAD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || sample.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_step_reg <= SQUARE_STEP_RST;
            saw_step_reg    <= SAW_STEP_RST;
            pend_reg        <= '0;
            saw_pos_reg     <= '0;
            acc_reg         <= '0;
            ch_reg          <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                vol_reg[i]    <= '0;
                per_lo_reg[i] <= '0;
                per_hi_reg[i] <= '0;
                per_reg[i]    <= '0;
                phase_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_PULSE; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SQUARE_STEP: square_step_reg <= cfg_data;
                    CFG_SAW_STEP:    saw_step_reg    <= cfg_data;
                    default:         ;
                endcase
            end

            if (wr_accept && wr_hit)
            begin
                case (wr_reg)
                    REG_VOL:    vol_reg[wr_ch] <= cmd.value;
                    REG_PER_LO:
                    begin
                        per_lo_reg[wr_ch] <= cmd.value;
                        pend_reg[wr_ch]   <= 1'b1;
                    end
                    REG_PER_HI:
                    begin
                        per_hi_reg[wr_ch] <= cmd.value;
                        pend_reg[wr_ch]   <= 1'b1;
                    end
                    default:    ; // spare register has no effect
                endcase
            end

            if (tick_accept)
                ch_reg <= CH_PULSE_A;

            if (state_reg == S_LOAD && pend_reg[ch_reg])
            begin
                per_reg[ch_reg]  <= PER_W'({per_hi_reg[ch_reg][3:0], per_lo_reg[ch_reg]})
                                    + PER_W'(1);
                pend_reg[ch_reg] <= 1'b0;
            end

            if (state_reg == S_CMP && cur_live && !sub_borrow)
                phase_reg[ch_reg] <= sub_diff[PHASE_W-1:0];

            // ceil division: exact fit leaves phase at zero
            if (state_reg == S_FIX)
                phase_reg[ch_reg] <= r_zero ? '0 : sub_diff[PHASE_W-1:0];

            if (state_reg == S_APPLY)
            begin
                if (cur_live)
                begin
                    if (ch_reg == CH_SAW)
                    begin
                        saw_pos_reg <= saw_pos_next;
                        acc_reg     <= acc_next;
                    end
                    else
                    begin
                        pos_reg[ch_reg[0]] <= pos_next;
                    end
                end
                ch_reg <= ch_reg + CH_W'(1);
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (sample.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_CMP:
            begin
                n4_reg   <= '0;
                nm7_reg  <= '0;
                nbig_reg <= 1'b0;
            end
            S_DEF:
            begin
                // deficit split: high part divided by the period, low part kept
                dq_reg   <= sub_diff[CFG_W-1:FRACTION_BITS];
                dl_reg   <= sub_diff[FRACTION_BITS-1:0];
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(QW - 1);
                qm7_reg  <= '0;
                qbig_reg <= 1'b0;
            end
            S_DIV:
            begin
                rem_reg  <= q_bit ? sub_diff[PER_W-1:0]
                                  : {rem_reg[PER_W-2:0], dq_reg[QW-1]};
                dq_reg   <= {dq_reg[QW-2:0], q_bit};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                qm7_reg  <= qm7_next;
                qbig_reg <= qbig_reg | qm7_ge7;
            end
            S_FIX:
            begin
                n4_reg   <= dq_reg[PULSE_POS_W-1:0] + PULSE_POS_W'(!r_zero);
                nm7_reg  <= (r_zero) ? qm7_reg
                            : ((qm7_reg == 3'd6) ? 3'd0 : qm7_reg + 3'd1);
                nbig_reg <= qbig_reg | (!r_zero && (qm7_reg == 3'd6));
            end
            S_APPLY:
            begin
                case (ch_reg)
                    CH_PULSE_A: lvl_a_reg <= pulse_lvl;
                    CH_PULSE_B: lvl_b_reg <= pulse_lvl;
                    CH_SAW:     lvl_s_reg <= saw_lvl;
                    default:    ;
                endcase
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_a_reg   <= lvl_a_reg;
            out_b_reg   <= lvl_b_reg;
            out_s_reg   <= lvl_s_reg;
            out_mix_reg <= MIX_LVL_W'(lvl_a_reg) + MIX_LVL_W'(lvl_b_reg)
                           + MIX_LVL_W'(lvl_s_reg);
        end
    end

    assign sample.valid         = out_valid_reg;
    assign sample.pulse_a_level = out_a_reg;
    assign sample.pulse_b_level = out_b_reg;
    assign sample.saw_level     = out_s_reg;
    assign sample.mixed_level   = out_mix_reg;

endmodule

@@ design/tpos_sub.sv @@
// ----------------------------------------------------------------------------
// tpos_sub
// Shared subtractor: phase compare, deficit, division steps, remainder fix.
// ----------------------------------------------------------------------------
module tpos_sub #(
    parameter int W = tpos_pkg::CFG_W + 1
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         borrow
);
    logic [W:0] full;

    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[W-1:0];
    assign borrow = full[W];
endmodule

@@ design/tpos_checker.sv @@
// ----------------------------------------------------------------------------
// tpos_checker
// Port-level checks of the sound generator, bound to the top level.
// ----------------------------------------------------------------------------
module tpos_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cmd_valid,
    input logic                             cmd_ready,
    input logic                             cmd_opcode,
    input logic                             sample_valid,
    input logic                             sample_ready,
    input logic [tpos_pkg::PULSE_LVL_W-1:0] pulse_a_level,
    input logic [tpos_pkg::PULSE_LVL_W-1:0] pulse_b_level,
    input logic [tpos_pkg::SAW_LVL_W-1:0]   saw_level,
    input logic [tpos_pkg::MIX_LVL_W-1:0]   mixed_level
);
    import tpos_pkg::*;

    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(mixed_level)
        && $stable(saw_level) && $stable(pulse_a_level) && $stable(pulse_b_level))
        else $error("sample changed while stalled");

    a_mix: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid |-> mixed_level == (MIX_LVL_W'(pulse_a_level)
        + MIX_LVL_W'(pulse_b_level) + MIX_LVL_W'(saw_level)))
        else $error("mixed level is not the channel sum");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_opcode == OP_TICK |=> !cmd_ready)
        else $error("command taken during tick");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_opcode == OP_WRITE && !sample_valid
        |=> !sample_valid)
        else $error("register write produced a result");

    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_valid) |-> $past(!cmd_ready))
        else $error("result appeared without a tick in progress");

endmodule

bind two_pulse_one_saw_sound_generator_unit tpos_checker u_tpos_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_opcode    (cmd.opcode),
    .sample_valid  (sample.valid),
    .sample_ready  (sample.ready),
    .pulse_a_level (sample.pulse_a_level),
    .pulse_b_level (sample.pulse_b_level),
    .saw_level     (sample.saw_level),
    .mixed_level   (sample.mixed_level)
);

@@ test/tpos_checker.sv @@
// ----------------------------------------------------------------------------
// tpos_scoreboard
// Watches the command, sample and step register ports of the sound generator.
// It keeps its own copy of the channel state and predicts the levels of every
// sample tick. Each sample transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tpos_scoreboard (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpos_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpos_pkg::CFG_W-1:0]     cfg_data,
    tpos_cmd_if                            cmd,
    tpos_sample_if                         sample,
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import tpos_pkg::*;

    typedef struct packed {
        logic [PULSE_LVL_W-1:0] pulse_a;
        logic [PULSE_LVL_W-1:0] pulse_b;
        logic [SAW_LVL_W-1:0]   saw;
        logic [MIX_LVL_W-1:0]   mix;
    } levels_t;

    // predicted channel state
    logic [CFG_W-1:0]       square_step;
    logic [CFG_W-1:0]       saw_step;
    logic [7:0]             regs [NUM_CH*4];
    logic                   reload_due [NUM_CH];
    longint                 period_fx [NUM_CH];
    longint                 phase [NUM_CH];
    logic [PULSE_POS_W-1:0] pulse_pos [NUM_PULSE];
    logic [SAW_POS_W-1:0]   saw_pos;
    logic [SAW_ACC_W-1:0]   saw_acc;

    levels_t levels_due [$];
    levels_t seen;
    levels_t want;
    int      errs;
    int      ch;

    // returns the number of underflows of channel c in this tick
    function automatic longint advance(input int c, input logic [CFG_W-1:0] stp);
        longint cur, deficit, per_fx, n;
        if (reload_due[c])
        begin
            per_fx = (longint'(regs[c*4 + REG_PER_HI][3:0]) << 8)
                   + longint'(regs[c*4 + REG_PER_LO]) + 1;
            period_fx[c] = per_fx << FRACTION_BITS_DEF;
            reload_due[c] = 1'b0;
        end
        if (period_fx[c] == 0)
            return 0;
        cur = phase[c] - longint'(stp);
        n = 0;
        if (cur < 0)
        begin
            // all underflows of the tick at once
            deficit = -cur;
            per_fx = period_fx[c];
            n = (deficit + per_fx - 1) / per_fx;
            cur = n * per_fx - deficit;
        end
        phase[c] = cur;
        return n;
    endfunction

    function automatic logic [PULSE_LVL_W-1:0] pulse_out(input int c);
        longint     n;
        logic [7:0] vol;
        n = advance(c, square_step);
        if (period_fx[c] == 0)
            return '0;
        pulse_pos[c] = pulse_pos[c] + n[3:0];
        vol = regs[c*4 + REG_VOL];
        if (!regs[c*4 + REG_PER_HI][7])
            return '0;
        // duty mode: positions 0..duty are low
        if (!vol[7] && int'(pulse_pos[c]) <= int'(vol[6:4]))
            return '0;
        return vol[3:0];
    endfunction

    function automatic logic [SAW_LVL_W-1:0] saw_out();
        longint     n, total;
        logic [5:0] rate;
        n = advance(CH_SAW, saw_step);
        if (period_fx[CH_SAW] == 0)
            return '0;
        rate = regs[CH_SAW*4 + REG_VOL][5:0];
        if (n > 0)
        begin
            total = longint'(saw_pos) + n;
            if (total >= SAW_STEPS)
            begin
                saw_pos = SAW_POS_W'(total % SAW_STEPS);
                saw_acc = SAW_ACC_W'(int'(saw_pos) * int'(rate));
            end
            else
            begin
                saw_acc = SAW_ACC_W'(longint'(saw_acc) + n * longint'(rate));
                saw_pos = SAW_POS_W'(total);
            end
        end
        if (!regs[CH_SAW*4 + REG_PER_HI][7])
            return '0;
        return saw_acc[7:3];
    endfunction

    function automatic levels_t tick_levels();
        levels_t lv;
        lv.pulse_a = pulse_out(CH_PULSE_A);
        lv.pulse_b = pulse_out(CH_PULSE_B);
        lv.saw     = saw_out();
        lv.mix     = MIX_LVL_W'(lv.pulse_a) + MIX_LVL_W'(lv.pulse_b) + MIX_LVL_W'(lv.saw);
        return lv;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_step = SQUARE_STEP_RST;
            saw_step    = SAW_STEP_RST;
            for (int i = 0; i < NUM_CH*4; i++)
                regs[i] = '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                reload_due[i] = 1'b0;
                period_fx[i]  = 0;
                phase[i]      = 0;
            end
            for (int i = 0; i < NUM_PULSE; i++)
                pulse_pos[i] = '0;
            saw_pos = '0;
            saw_acc = '0;
            levels_due.delete();
            errs = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SQUARE_STEP: square_step = cfg_data;
                    CFG_SAW_STEP:    saw_step    = cfg_data;
                    default: ;
                endcase
            end

            // compare before predicting: a tick taken at this edge has no result yet
            if (sample.valid && sample.ready)
            begin
                seen = '{sample.pulse_a_level, sample.pulse_b_level,
                         sample.saw_level, sample.mixed_level};
                if (levels_due.size() == 0)
                begin
                    if (errs < 10)
                        $display("%0t checker: sample transfer with nothing predicted", $realtime);
                    errs++;
                end
                else
                begin
                    want = levels_due.pop_front();
                    if (seen.pulse_a != want.pulse_a || seen.pulse_b != want.pulse_b ||
                        seen.saw != want.saw || seen.mix != want.mix)
                    begin
                        if (errs < 10)
                            $display({"%0t checker: levels exp a=%0d b=%0d saw=%0d mix=%0d",
                                      " got a=%0d b=%0d saw=%0d mix=%0d"}, $realtime,
                                     want.pulse_a, want.pulse_b, want.saw, want.mix,
                                     seen.pulse_a, seen.pulse_b, seen.saw, seen.mix);
                        errs++;
                    end
                end
            end

            if (cmd.valid && cmd.ready)
            begin
                if (cmd.opcode == OP_TICK)
                    levels_due.push_back(tick_levels());
                else
                begin
                    case (cmd.address[15:12])
                        SEL_PULSE_A: ch = CH_PULSE_A;
                        SEL_PULSE_B: ch = CH_PULSE_B;
                        SEL_SAW:     ch = CH_SAW;
                        default:     ch = -1;   // unmapped, ignored
                    endcase
                    if (ch >= 0)
                    begin
                        regs[ch*4 + cmd.address[1:0]] = cmd.value;
                        if (cmd.address[1:0] == REG_PER_LO || cmd.address[1:0] == REG_PER_HI)
                            reload_due[ch] = 1'b1;
                    end
                end
            end

            mismatches  <= errs;
            outstanding <= levels_due.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the two pulse / one sawtooth sound generator: a directed
// opening, then random register writes and sample ticks under several step
// settings, with bursty command traffic and a stalling sample receiver.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tpos_pkg::*;

    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 275;
    localparam int DRAIN_CYCLES = 64;     // longer than the slowest tick
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 300;    // samples before the long hold-off
    localparam int IDLE_LIMIT   = 4000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;

    tpos_cmd_if    cmd_bus ();
    tpos_sample_if sample_bus ();

    two_pulse_one_saw_sound_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .sample    (sample_bus)
    );

    tpos_scoreboard u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd_bus),
        .sample      (sample_bus),
        .mismatches  (fail_count),
        .outstanding (pending)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // sample receiver: random stall pattern plus one long hold-off
    // ------------------------------------------------------------------------
    int samples_taken;
    int hold_left;
    bit hold_done;
    int stall_mode;
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bus.ready <= 1'b0;
            samples_taken = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end
        else
        begin
            if (sample_bus.valid && sample_bus.ready)
                samples_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                sample_bus.ready <= 1'b0;
            end
            else if (!hold_done && samples_taken >= HOLD_AFTER)
            begin
                // fill the block up so the command side stalls
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                sample_bus.ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    stall_left = $urandom_range(10, 150);
                end
                stall_left--;
                case (stall_mode)
                    0:       sample_bus.ready <= 1'b1;
                    1:       sample_bus.ready <= ($urandom_range(0, 1) == 0);
                    default: sample_bus.ready <= ($urandom_range(0, 99) < 15);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transfer at all
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (sample_bus.valid && sample_bus.ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] chan_addr(input logic [3:0] sel,
                                                     input logic [1:0] rsel);
        return {sel, 10'h000, rsel};
    endfunction

    // offer one command and hold it until the transfer
    task automatic send_cmd(input logic op, input logic [ADDR_W-1:0] addr,
                            input logic [VALUE_W-1:0] val);
        cmd_bus.valid   <= 1'b1;
        cmd_bus.opcode  <= op;
        cmd_bus.address <= addr;
        cmd_bus.value   <= val;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
    endtask

    task automatic write_steps(input logic [CFG_W-1:0] sq, input logic [CFG_W-1:0] sw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SQUARE_STEP;
        cfg_data  <= sq;
        @(posedge clk);
        cfg_index <= CFG_SAW_STEP;
        cfg_data  <= sw;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait for every predicted sample, then let a tick's worth of cycles pass
    task automatic settle();
        // the scoreboard's outstanding count is registered and lags the last transfer
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int               done;
        int               burst_left;
        int               gap;
        int               pick;
        logic             op;
        logic [ADDR_W-1:0] addr;
        logic [VALUE_W-1:0] val;
        logic [3:0]       sel;
        done = 0;
        burst_left = 0;
        while (done < count)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    cmd_bus.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            val  = VALUE_W'($urandom);
            if (pick < 50)
            begin
                op   = OP_TICK;
                addr = ADDR_W'($urandom);
            end
            else if (pick < 90)
            begin
                op = OP_WRITE;
                case ($urandom_range(0, 2))
                    0:       sel = SEL_PULSE_A;
                    1:       sel = SEL_PULSE_B;
                    default: sel = SEL_SAW;
                endcase
                addr = {sel, 12'($urandom)};
                // short periods so that underflows come often
                if (addr[1:0] == REG_PER_LO && $urandom_range(0, 1) == 0)
                    val = VALUE_W'($urandom_range(0, 15));
                else if (addr[1:0] == REG_PER_HI && $urandom_range(0, 9) < 6)
                    val[3:0] = 4'h0;
            end
            else
            begin
                op   = OP_WRITE;
                addr = ADDR_W'($urandom);
            end
            send_cmd(op, addr, val);
            done++;
        end
        cmd_bus.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_SQUARE_STEP;
        cfg_data        <= '0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.opcode  <= OP_TICK;
        cmd_bus.address <= '0;
        cmd_bus.value   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, reset step values
        send_cmd(OP_TICK, 16'h0000, 8'h00);                     // nothing loaded: silent
        send_cmd(OP_WRITE, 16'h0000, 8'hFF);                    // unmapped
        send_cmd(OP_WRITE, 16'hFFFF, 8'hFF);                    // unmapped
        send_cmd(OP_WRITE, chan_addr(SEL_PULSE_A, REG_VOL), 8'h8F);    // constant 15
        send_cmd(OP_WRITE, chan_addr(SEL_PULSE_A, REG_PER_LO), 8'hFF);
        send_cmd(OP_WRITE, chan_addr(SEL_PULSE_A, REG_PER_HI), 8'h8F); // longest period
        send_cmd(OP_TICK, 16'hFFFF, 8'hFF);
        send_cmd(OP_WRITE, chan_addr(SEL_PULSE_B, REG_VOL), 8'h7A);    // widest duty
        send_cmd(OP_WRITE, chan_addr(SEL_PULSE_B, REG_PER_LO), 8'h00);
        send_cmd(OP_WRITE, chan_addr(SEL_PULSE_B, REG_PER_HI), 8'h80); // shortest period
        send_cmd(OP_TICK, 16'h0000, 8'h00);
        send_cmd(OP_TICK, 16'h0000, 8'h00);
        send_cmd(OP_WRITE, chan_addr(SEL_SAW, REG_VOL), 8'hFF);        // top rate
        send_cmd(OP_WRITE, chan_addr(SEL_SAW, REG_PER_LO), 8'h00);
        send_cmd(OP_WRITE, chan_addr(SEL_SAW, REG_PER_HI), 8'h80);
        send_cmd(OP_TICK, 16'h0000, 8'h00);
        send_cmd(OP_TICK, 16'h0000, 8'h00);
        send_cmd(OP_TICK, 16'h0000, 8'h00);                     // saw at 6; wraps after seven
        send_cmd(OP_WRITE, 16'h9FFF, 8'h55);                    // spare register, no reload
        send_cmd(OP_WRITE, chan_addr(SEL_SAW, REG_SPARE), 8'hAA);
        send_cmd(OP_WRITE, chan_addr(SEL_PULSE_A, REG_PER_HI), 8'h0F); // disabled, still runs
        send_cmd(OP_TICK, 16'h0000, 8'h00);
        send_cmd(OP_WRITE, chan_addr(SEL_PULSE_B, REG_VOL), 8'h00);
        send_cmd(OP_WRITE, 16'h8FFF, 8'h00);                    // unmapped
        send_cmd(OP_WRITE, 16'hC000, 8'hFF);                    // unmapped
        send_cmd(OP_TICK, 16'h0000, 8'h00);

        run_random(PHASE_ITEMS);
        for (int ph = 1; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                1:       write_steps('1, '1);
                2:       write_steps('0, '0);
                3:       write_steps(CFG_W'($urandom), CFG_W'($urandom));
                4:       write_steps(CFG_W'($urandom_range(1 << 16, 1 << 21)),
                                     CFG_W'($urandom_range(1 << 16, 1 << 21)));
                default: write_steps(CFG_W'(1), '1);
            endcase
            run_random(PHASE_ITEMS);
        end
        settle();

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
